/* rtl/core/cfmaf_pkg.sv */
// ----------------------------------------------------------------------------
// cfmaf_pkg
// Types, codes and sizes shared by the first-match CIDR access filter.
// ----------------------------------------------------------------------------
package cfmaf_pkg;

  localparam int unsigned V4RulesDefault = 16;
  localparam int unsigned V6RulesDefault = 16;

  localparam logic [1:0] MODE_APPEND = 2'd0;
  localparam logic [1:0] MODE_CLEAR  = 2'd1;
  localparam logic [1:0] MODE_LOOKUP = 2'd2;
  localparam logic [1:0] MODE_IGNORE = 2'd3;

  localparam logic [1:0] FAM_V4    = 2'd0;
  localparam logic [1:0] FAM_V6    = 2'd1;
  localparam logic [1:0] FAM_LOCAL = 2'd2;
  localparam logic [1:0] FAM_ALL   = 2'd3;

  localparam logic [1:0] VERDICT_DECLINED = 2'd0;
  localparam logic [1:0] VERDICT_ALLOWED  = 2'd1;
  localparam logic [1:0] VERDICT_FORBID   = 2'd2;

  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_DROPPED = 1'b1;

  typedef enum logic [1:0] {
    OP_NOP,
    OP_APPEND,
    OP_CLEAR,
    OP_LOOKUP
  } op_e;

  typedef enum logic {
    ST_IDLE,
    ST_WALK
  } state_e;

  typedef struct packed {
    logic [1:0]  mode;
    logic [1:0]  family;
    logic [63:0] addr_hi;
    logic [63:0] addr_lo;
    logic [63:0] mask_hi;
    logic [63:0] mask_lo;
    logic        deny;
  } in_item_t;

  typedef struct packed {
    logic [1:0] verdict;
    logic [3:0] matched_index;
    logic       status;
  } out_item_t;

  // Classified command passed from front to back. For appends the address
  // is already masked.
  typedef struct packed {
    op_e         op;
    logic [1:0]  family;
    logic [63:0] addr_hi;
    logic [63:0] addr_lo;
    logic [63:0] mask_hi;
    logic [63:0] mask_lo;
    logic        deny;
    logic        mapped;
  } cmd_t;

  function automatic logic [1:0] verdict_of(input logic deny);
    return deny ? VERDICT_FORBID : VERDICT_ALLOWED;
  endfunction

endpackage

/* rtl/core/cfmaf_ram.sv */
// ----------------------------------------------------------------------------
// cfmaf_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module cfmaf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/cfmaf_front.sv */
// ----------------------------------------------------------------------------
// cfmaf_front
// Accepts input words, classifies them into commands and queues them in a
// two-entry queue for the back end.
// ----------------------------------------------------------------------------
module cfmaf_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  cfmaf_pkg::in_item_t  in_data_i,
  output logic                 cmd_valid_o,
  input  logic                 cmd_pop_i,
  output cfmaf_pkg::cmd_t      cmd_o
);
  import cfmaf_pkg::*;

  cmd_t       slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] fill_q, fill_d;
  cmd_t       cls;
  logic       push;
  logic       all_fam;

  always_comb begin
    all_fam    = (in_data_i.family == FAM_ALL);
    cls        = '0;
    cls.family = in_data_i.family;
    cls.deny   = in_data_i.deny;
    case (in_data_i.mode)
      MODE_APPEND: begin
        cls.op = OP_APPEND;
        if (!all_fam) begin
          cls.mask_hi = in_data_i.mask_hi;
          cls.mask_lo = in_data_i.mask_lo;
          cls.addr_hi = in_data_i.addr_hi & in_data_i.mask_hi;
          cls.addr_lo = in_data_i.addr_lo & in_data_i.mask_lo;
        end
      end
      MODE_CLEAR: begin
        cls.op = OP_CLEAR;
      end
      MODE_LOOKUP: begin
        cls.op      = OP_LOOKUP;
        cls.addr_hi = in_data_i.addr_hi;
        cls.addr_lo = in_data_i.addr_lo;
        cls.mapped  = (in_data_i.addr_hi == 64'd0) &&
                      (in_data_i.addr_lo[63:32] == 32'h0000_FFFF);
      end
      default: begin
        cls.op = OP_NOP;
      end
    endcase
  end

  assign in_stall_o  = (fill_q == 2'd2);
  assign push        = in_valid_i && !in_stall_o;
  assign cmd_valid_o = (fill_q != 2'd0);
  assign cmd_o       = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = cmd_pop_i ? !rd_ptr_q : rd_ptr_q;
    fill_d   = fill_q + {1'b0, push} - {1'b0, cmd_pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= cls;
    end
  end

`ifndef ASSERT_OFF
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= 2'd2) else $error("queue overfilled");
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_i |-> fill_q != 2'd0) else $error("pop from empty queue");
  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !cmd_pop_i) |=> fill_q == $past(fill_q) + 2'd1)
    else $error("push lost");
`endif

endmodule

/* rtl/core/cfmaf_back.sv */
// ----------------------------------------------------------------------------
// cfmaf_back
// Executes commands: rule appends, table clear, and first-match lookups
// walking one rule per cycle through the rule RAMs.
// ----------------------------------------------------------------------------
module cfmaf_back #(
  parameter int unsigned V4_RULES = cfmaf_pkg::V4RulesDefault,
  parameter int unsigned V6_RULES = cfmaf_pkg::V6RulesDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cmd_valid_i,
  output logic                 cmd_pop_o,
  input  cfmaf_pkg::cmd_t      cmd_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output cfmaf_pkg::out_item_t out_data_o
);
  import cfmaf_pkg::*;

  localparam int unsigned V4_AW = (V4_RULES > 1) ? $clog2(V4_RULES) : 1;
  localparam int unsigned V6_AW = (V6_RULES > 1) ? $clog2(V6_RULES) : 1;
  localparam int unsigned V4_CW = $clog2(V4_RULES + 1);
  localparam int unsigned V6_CW = $clog2(V6_RULES + 1);
  localparam int unsigned MAXR  = (V4_RULES > V6_RULES) ? V4_RULES : V6_RULES;
  localparam int unsigned IW    = $clog2(MAXR + 1);
  localparam int unsigned V4_W  = 65;
  localparam int unsigned V6_W  = 257;

  state_e           state_q, state_d;
  logic [V4_CW-1:0] v4_cnt_q, v4_cnt_d;
  logic [V6_CW-1:0] v6_cnt_q, v6_cnt_d;
  logic             loc_present_q, loc_present_d;
  logic             loc_deny_q, loc_deny_d;
  logic [IW-1:0]    idx_q, idx_d;
  logic             use_v6_q, use_v6_d;
  logic [63:0]      addr_hi_q, addr_lo_q;
  logic             out_valid_q, out_valid_d;
  out_item_t        out_q, out_d;

  logic             out_free;
  logic             load;
  logic             we4, we6;
  logic [IW-1:0]    idx_nxt, rd_idx, sel_cnt;
  logic [V4_W-1:0]  v4_rd;
  logic [V6_W-1:0]  v6_rd;
  logic             hit4, hit6, hit, hit_deny;
  logic             all_fam;

  assign out_free = !out_valid_q || !out_stall_i;
  assign idx_nxt  = idx_q + 1'b1;
  assign rd_idx   = (state_q == ST_WALK) ? idx_nxt : '0;
  assign sel_cnt  = use_v6_q ? IW'(v6_cnt_q) : IW'(v4_cnt_q);
  assign all_fam  = (cmd_i.family == FAM_ALL);

  cfmaf_ram #(.WIDTH(V4_W), .DEPTH(V4_RULES)) u_v4_ram (
    .clk_i   (clk_i),
    .we_i    (we4),
    .waddr_i (v4_cnt_q[V4_AW-1:0]),
    .wdata_i ({cmd_i.mask_lo[31:0], cmd_i.addr_lo[31:0], cmd_i.deny}),
    .raddr_i (rd_idx[V4_AW-1:0]),
    .rdata_o (v4_rd)
  );

  cfmaf_ram #(.WIDTH(V6_W), .DEPTH(V6_RULES)) u_v6_ram (
    .clk_i   (clk_i),
    .we_i    (we6),
    .waddr_i (v6_cnt_q[V6_AW-1:0]),
    .wdata_i ({cmd_i.mask_hi, cmd_i.mask_lo, cmd_i.addr_hi, cmd_i.addr_lo, cmd_i.deny}),
    .raddr_i (rd_idx[V6_AW-1:0]),
    .rdata_o (v6_rd)
  );

  // RAM word layout: mask, address, deny (low bit)
  assign hit4 = ((addr_lo_q[31:0] & v4_rd[64:33]) == v4_rd[32:1]);
  assign hit6 = ((addr_hi_q & v6_rd[256:193]) == v6_rd[128:65]) &&
                ((addr_lo_q & v6_rd[192:129]) == v6_rd[64:1]);
  assign hit      = use_v6_q ? hit6 : hit4;
  assign hit_deny = use_v6_q ? v6_rd[0] : v4_rd[0];

  always_comb begin
    state_d       = state_q;
    v4_cnt_d      = v4_cnt_q;
    v6_cnt_d      = v6_cnt_q;
    loc_present_d = loc_present_q;
    loc_deny_d    = loc_deny_q;
    idx_d         = idx_q;
    use_v6_d      = use_v6_q;
    cmd_pop_o     = 1'b0;
    load          = 1'b0;
    out_d         = '0;
    we4           = 1'b0;
    we6           = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i && out_free) begin
          cmd_pop_o = 1'b1;
          case (cmd_i.op)
            OP_APPEND: begin
              load = 1'b1;
              if ((cmd_i.family == FAM_V4) || all_fam) begin
                if (v4_cnt_q < V4_CW'(V4_RULES)) begin
                  we4      = 1'b1;
                  v4_cnt_d = v4_cnt_q + 1'b1;
                end else begin
                  out_d.status = STATUS_DROPPED;
                end
              end
              if ((cmd_i.family == FAM_V6) || all_fam) begin
                if (v6_cnt_q < V6_CW'(V6_RULES)) begin
                  we6      = 1'b1;
                  v6_cnt_d = v6_cnt_q + 1'b1;
                end else begin
                  out_d.status = STATUS_DROPPED;
                end
              end
              if (((cmd_i.family == FAM_LOCAL) || all_fam) && !loc_present_q) begin
                loc_present_d = 1'b1;
                loc_deny_d    = cmd_i.deny;
              end
            end
            OP_CLEAR: begin
              load          = 1'b1;
              v4_cnt_d      = '0;
              v6_cnt_d      = '0;
              loc_present_d = 1'b0;
              loc_deny_d    = 1'b0;
            end
            OP_LOOKUP: begin
              idx_d = '0;
              case (cmd_i.family)
                FAM_V4: begin
                  use_v6_d = 1'b0;
                  if (v4_cnt_q != '0) begin
                    state_d = ST_WALK;
                  end else begin
                    load = 1'b1;
                  end
                end
                FAM_V6: begin
                  if (cmd_i.mapped && (v4_cnt_q != '0)) begin
                    use_v6_d = 1'b0;
                    state_d  = ST_WALK;
                  end else if (v6_cnt_q != '0) begin
                    use_v6_d = 1'b1;
                    state_d  = ST_WALK;
                  end else begin
                    load = 1'b1;
                  end
                end
                FAM_LOCAL: begin
                  load = 1'b1;
                  if (loc_present_q) begin
                    out_d.verdict = verdict_of(loc_deny_q);
                  end
                end
                default: begin
                  load = 1'b1;
                end
              endcase
            end
            default: begin
              load = 1'b1;
            end
          endcase
        end
      end
      ST_WALK: begin
        if (hit) begin
          load                = 1'b1;
          out_d.verdict       = verdict_of(hit_deny);
          out_d.matched_index = 4'(idx_q);
          state_d             = ST_IDLE;
        end else if (idx_nxt == sel_cnt) begin
          load    = 1'b1;
          state_d = ST_IDLE;
        end else begin
          idx_d = idx_nxt;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      v4_cnt_q      <= '0;
      v6_cnt_q      <= '0;
      loc_present_q <= 1'b0;
      loc_deny_q    <= 1'b0;
      idx_q         <= '0;
      use_v6_q      <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      v4_cnt_q      <= v4_cnt_d;
      v6_cnt_q      <= v6_cnt_d;
      loc_present_q <= loc_present_d;
      loc_deny_q    <= loc_deny_d;
      idx_q         <= idx_d;
      use_v6_q      <= use_v6_d;
      out_valid_q   <= out_valid_d;
    end
  end

  // hold the client address for the walk
  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      addr_hi_q <= cmd_i.addr_hi;
      addr_lo_q <= cmd_i.addr_lo;
    end
    if (load) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef ASSERT_OFF
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |-> out_free) else $error("result overwrites pending word");
  a_walk_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK) |-> idx_q < sel_cnt) else $error("walk past table end");
  a_v4_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v4_cnt_q <= V4_CW'(V4_RULES)) else $error("ipv4 count overflow");
  a_no_pop_in_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK) |-> !cmd_pop_o) else $error("pop during walk");
`endif

endmodule

/* rtl/core/cidr_first_match_access_filter_top.sv */
// ----------------------------------------------------------------------------
// cidr_first_match_access_filter_top
// First-match CIDR allow/deny filter for IPv4, IPv6 and local clients.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+----------------------------
//   in      | input     | in_valid_i/stall_o | in_data_i  (in_item_t)
//   out     | output    | out_valid_o/stall_i| out_data_o (out_item_t)
//
// Append, clear and non-walking lookups pass through the front queue and are
// answered from the back end's result register. A table lookup scans rules in
// order, one rule a cycle through the IPv4 or IPv6 masked comparator.
// Reset empties all tables at once through the rule counts; no clearing pass.
// A two-word queue lets input be accepted while a result waits on out stall.
// ----------------------------------------------------------------------------
module cidr_first_match_access_filter_top #(
  parameter int unsigned V4_RULES = cfmaf_pkg::V4RulesDefault,
  parameter int unsigned V6_RULES = cfmaf_pkg::V6RulesDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  cfmaf_pkg::in_item_t  in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output cfmaf_pkg::out_item_t out_data_o
);
  import cfmaf_pkg::*;

  cmd_t cmd;
  logic cmd_valid;
  logic cmd_pop;

  cfmaf_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .cmd_valid_o (cmd_valid),
    .cmd_pop_i   (cmd_pop),
    .cmd_o       (cmd)
  );

  cfmaf_back #(.V4_RULES(V4_RULES), .V6_RULES(V6_RULES)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_pop_o   (cmd_pop),
    .cmd_i       (cmd),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

/* test/cfmaf_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfmaf_checker
// Watches both channels of the access filter, keeps its own copy of the rule
// tables, predicts each result word and compares it with what comes out.
// ----------------------------------------------------------------------------
module cfmaf_checker (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_stall_i,
  input  cfmaf_pkg::in_item_t  in_data_i,
  input  logic                 out_valid_i,
  input  logic                 out_stall_i,
  input  cfmaf_pkg::out_item_t out_data_i,
  output int                   errors_o,
  output int                   pending_o
);
  import cfmaf_pkg::*;

  logic [31:0] v4_addr [16];
  logic [31:0] v4_mask [16];
  logic        v4_deny [16];
  int          v4_count;
  logic [63:0] v6_addr_hi [16];
  logic [63:0] v6_addr_lo [16];
  logic [63:0] v6_mask_hi [16];
  logic [63:0] v6_mask_lo [16];
  logic        v6_deny [16];
  int          v6_count;
  logic        local_present;
  logic        local_deny;

  out_item_t verdict_q[$];

  assign pending_o = verdict_q.size();

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    $display("%0t mismatch %s: got %0d want %0d", $time, what, got, want);
    errors_o++;
  endtask

  function automatic out_item_t filter_word(input in_item_t w);
    out_item_t r;
    logic all;
    logic [63:0] ahi, alo, mhi, mlo;
    logic use4, use6;
    r = '0;
    ahi = w.addr_hi; alo = w.addr_lo; mhi = w.mask_hi; mlo = w.mask_lo;
    use4 = 1'b0; use6 = 1'b0;
    if (w.mode == MODE_APPEND) begin
      all = (w.family == FAM_ALL);
      if (all) begin
        ahi = '0; alo = '0; mhi = '0; mlo = '0;
      end
      if (w.family == FAM_V4 || all) begin
        if (v4_count < 16) begin
          v4_mask[v4_count] = mlo[31:0];
          v4_addr[v4_count] = alo[31:0] & mlo[31:0];
          v4_deny[v4_count] = w.deny;
          v4_count++;
        end else r.status = STATUS_DROPPED;
      end
      if (w.family == FAM_V6 || all) begin
        if (v6_count < 16) begin
          v6_mask_hi[v6_count] = mhi;
          v6_mask_lo[v6_count] = mlo;
          v6_addr_hi[v6_count] = ahi & mhi;
          v6_addr_lo[v6_count] = alo & mlo;
          v6_deny[v6_count] = w.deny;
          v6_count++;
        end else r.status = STATUS_DROPPED;
      end
      if ((w.family == FAM_LOCAL || all) && !local_present) begin
        local_present = 1'b1;
        local_deny = w.deny;
      end
    end else if (w.mode == MODE_CLEAR) begin
      v4_count = 0;
      v6_count = 0;
      local_present = 1'b0;
      local_deny = 1'b0;
    end else if (w.mode == MODE_LOOKUP) begin
      if (w.family == FAM_V4) use4 = 1'b1;
      else if (w.family == FAM_V6) begin
        if (ahi == 0 && alo[63:32] == 32'hFFFF && v4_count > 0) use4 = 1'b1;
        else use6 = 1'b1;
      end else if (w.family == FAM_LOCAL && local_present)
        r.verdict = local_deny ? VERDICT_FORBID : VERDICT_ALLOWED;
      if (use4) begin
        for (int i = 0; i < v4_count; i++) begin
          if ((alo[31:0] & v4_mask[i]) == v4_addr[i]) begin
            r.verdict = v4_deny[i] ? VERDICT_FORBID : VERDICT_ALLOWED;
            r.matched_index = i[3:0];
            break;
          end
        end
      end
      if (use6) begin
        for (int i = 0; i < v6_count; i++) begin
          if ((ahi & v6_mask_hi[i]) == v6_addr_hi[i] &&
              (alo & v6_mask_lo[i]) == v6_addr_lo[i]) begin
            r.verdict = v6_deny[i] ? VERDICT_FORBID : VERDICT_ALLOWED;
            r.matched_index = i[3:0];
            break;
          end
        end
      end
    end
    return r;
  endfunction

  initial begin
    errors_o = 0;
    v4_count = 0;
    v6_count = 0;
    local_present = 1'b0;
    local_deny = 1'b0;
  end

  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_i) verdict_q.push_back(filter_word(in_data_i));
      if (out_valid_i && !out_stall_i) begin
        if (verdict_q.size() == 0) begin
          $display("%0t unexpected result word", $time);
          errors_o++;
        end else begin
          want = verdict_q.pop_front();
          if (out_data_i.verdict !== want.verdict)
            report_mismatch("verdict", out_data_i.verdict, want.verdict);
          if (out_data_i.matched_index !== want.matched_index)
            report_mismatch("matched_index", out_data_i.matched_index,
                            want.matched_index);
          if (out_data_i.status !== want.status)
            report_mismatch("status", out_data_i.status, want.status);
        end
      end
    end
  end

endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives directed and random rule appends, clears and lookups into the access
// filter with random idling on both sides; the checker judges every result.
// ----------------------------------------------------------------------------
module testbench;
  import cfmaf_pkg::*;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  in_item_t  in_data_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_data_o;
  int        errors;
  int        pending;
  logic      calm = 1'b0;

  // Addresses drawn from a small pool so lookups actually hit rules.
  logic [63:0] pool_hi [4];
  logic [63:0] pool_lo [4];

  always #5 clk_i = ~clk_i;

  cidr_first_match_access_filter_top u_top (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o
  );

  cfmaf_checker u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .in_data_i,
    .out_valid_i(out_valid_o), .out_stall_i, .out_data_i(out_data_o),
    .errors_o(errors), .pending_o(pending)
  );

  always @(posedge clk_i) begin
    out_stall_i <= calm ? 1'b0 : ($urandom_range(99) < 37);
  end

  // Drop valid only while idling, so back-to-back words keep it high.
  task automatic send_word(input in_item_t w);
    while (!calm && $urandom_range(99) < 37) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= w;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  function automatic logic [63:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] prefix_mask64(input int n);
    return (n == 0) ? 64'd0 : ~(64'd0) << (64 - n);
  endfunction

  function automatic in_item_t make_word(input logic [1:0] mode,
                                         input logic [1:0] fam,
                                         input logic [63:0] ahi,
                                         input logic [63:0] alo,
                                         input logic [63:0] mhi,
                                         input logic [63:0] mlo,
                                         input logic dn);
    in_item_t w;
    w.mode = mode; w.family = fam; w.addr_hi = ahi; w.addr_lo = alo;
    w.mask_hi = mhi; w.mask_lo = mlo; w.deny = dn;
    return w;
  endfunction

  function automatic in_item_t random_word();
    in_item_t w;
    int p, k, len;
    logic [63:0] m;
    p = $urandom_range(3);
    k = $urandom_range(99);
    w = make_word(MODE_LOOKUP, 2'($urandom_range(3)), pool_hi[p], pool_lo[p],
                  rnd64(), rnd64(), 1'($urandom_range(1)));
    if ($urandom_range(3) == 0) begin
      w.addr_hi = rnd64(); w.addr_lo = rnd64();
    end
    if ($urandom_range(3) == 0) begin
      w.addr_hi = 64'd0;
      w.addr_lo = {32'h0000FFFF, pool_lo[p][31:0]};
    end
    if (k < 40) begin
      w.mode = MODE_APPEND;
      len = $urandom_range(128);
      m = prefix_mask64(len > 64 ? 64 : len);
      w.mask_hi = m;
      w.mask_lo = prefix_mask64(len > 64 ? len - 64 : 0);
      if (w.family == FAM_V4) w.mask_lo = {32'd0, ~(32'd0) << (32 - len % 33)};
      if ($urandom_range(9) == 0) begin
        w.mask_hi = rnd64(); w.mask_lo = rnd64();
      end
    end else if (k < 43) w.mode = MODE_CLEAR;
    else if (k < 45) w.mode = MODE_IGNORE;
    return w;
  endfunction

  initial begin
    in_item_t w;
    for (int i = 0; i < 4; i++) begin
      pool_hi[i] = rnd64();
      pool_lo[i] = rnd64();
    end
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // Empty tables, then rules at the extremes.
    send_word(make_word(MODE_LOOKUP, FAM_V4, '0, '0, '0, '0, 1'b0));
    send_word(make_word(MODE_LOOKUP, FAM_LOCAL, '1, '1, '1, '1, 1'b1));
    send_word(make_word(MODE_APPEND, FAM_V4, '1, '1, '1, 64'hFFFF_FF00, 1'b1));
    send_word(make_word(MODE_APPEND, FAM_V6, '1, '1, '1, '1, 1'b0));
    send_word(make_word(MODE_APPEND, FAM_LOCAL, '0, '0, '0, '0, 1'b1));
    send_word(make_word(MODE_APPEND, FAM_LOCAL, '0, '0, '0, '0, 1'b0));
    send_word(make_word(MODE_LOOKUP, FAM_V4, '1, '1, '0, '0, 1'b0));
    send_word(make_word(MODE_LOOKUP, FAM_V6, '1, '1, '0, '0, 1'b0));
    send_word(make_word(MODE_LOOKUP, FAM_V6, '0, 64'h0000_FFFF_FFFF_FF01, '0, '0, 1'b0));
    send_word(make_word(MODE_LOOKUP, FAM_LOCAL, '0, '0, '0, '0, 1'b0));
    send_word(make_word(MODE_LOOKUP, FAM_ALL, '0, '0, '0, '0, 1'b0));
    send_word(make_word(MODE_IGNORE, FAM_ALL, '1, '1, '1, '1, 1'b1));
    for (int i = 0; i < 16; i++)
      send_word(make_word(MODE_APPEND, FAM_ALL, '1, '1, '1, '1, i[0]));
    send_word(make_word(MODE_LOOKUP, FAM_V6, '0, '0, '0, '0, 1'b0));
    send_word(make_word(MODE_CLEAR, FAM_V4, '1, '1, '1, '1, 1'b1));
    send_word(make_word(MODE_LOOKUP, FAM_V6, '0, 64'h0000_FFFF_0000_0000, '0, '0, 1'b0));
    // Hold until everything has drained.
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    for (int n = 0; n < 1250; n++) begin
      calm <= (n >= 500 && n < 650);
      send_word(random_word());
    end
    calm <= 1'b0;
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (errors == 0) $display("PASS cidr_first_match_access_filter_top");
    else $display("FAIL cidr_first_match_access_filter_top");
    $finish;
  end

  initial begin
    #5ms;
    $display("FAIL cidr_first_match_access_filter_top");
    $finish;
  end

endmodule
